>>> sv/multitone_tune_modulator_core_assert.svh
// ----------------------------------------------------------------------------
// multitone tune modulator assertion macros
// concurrent checks, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef MULTITONE_TUNE_MODULATOR_CORE_ASSERT_SVH
`define MULTITONE_TUNE_MODULATOR_CORE_ASSERT_SVH

`ifndef SYNTH
`define MTM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mtm assertion failed");
`define MTM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mtm assertion failed");
`else
`define MTM_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MTM_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> sv/mtm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtm_pkg
// shared constants, register codes and table functions of the tune modulator
// ----------------------------------------------------------------------------
package mtm_pkg;

  typedef enum logic [2:0] {
    REG_MODE         = 3'd0,
    REG_TUNE         = 3'd1,
    REG_EPSILON      = 3'd2,
    REG_TONE_FREQ    = 3'd3,
    REG_START_OFFSET = 3'd4
  } cfg_reg_t;

  localparam int unsigned NUM_TONES = 7;

  // multitone period times 100
  localparam logic [16:0] PERIOD    = 17'd86812;
  localparam logic [16:0] RECIP_N   = 17'((64'd1 << 33) / 64'd86812);
  localparam logic [10:0] RECIP_V   = 11'((64'd1 << 27) / 64'd86812);
  localparam logic [32:0] RECIP_PH  = 33'((64'd1 << 49) / 64'd86812);

  localparam logic [63:0] HALF_PI_Q32 = 64'd6746518852;
  localparam logic [30:0] TWO_PI_Q28  = 31'd1686629713;

  localparam logic [47:0] POS_LIMIT = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] NEG_LIMIT = 48'h8000_0000_0000;

  // 100 times the harmonic number
  function automatic logic [10:0] tone_mult(input int unsigned j);
    logic [10:0] m;
    unique case (j)
      0:       m = 11'd100;
      1:       m = 11'd200;
      2:       m = 11'd300;
      3:       m = 11'd600;
      4:       m = 11'd700;
      5:       m = 11'd1000;
      default: m = 11'd1200;
    endcase
    return m;
  endfunction

  // tone weights, Q0.40
  function automatic logic [26:0] tone_coef(input int unsigned j);
    logic [26:0] c;
    unique case (j)
      0:       c = 27'd109951163;
      1:       c = 27'd23969353;
      2:       c = 27'd77845423;
      3:       c = 27'd27927595;
      4:       c = 27'd10995116;
      5:       c = 27'd8576191;
      default: c = 27'd23969353;
    endcase
    return c;
  endfunction

  // quarter-wave cosine entry, Q1.30, from an eleven-term Taylor series
  function automatic logic [30:0] cos_entry(input int unsigned k, input int unsigned tb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x    = (64'(k) * HALF_PI_Q32) >> (tb + 2);
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = longint'(1) << 30;
    for (int n = 1; n <= 10; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (longint'(1) << 30)) begin
      sum = longint'(1) << 30;
    end
    return sum[30:0];
  endfunction

endpackage

>>> sv/mtm_cos_lut.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtm_cos_lut
// two-stage cosine lookup: quadrant fold, then quarter-wave table read
// ----------------------------------------------------------------------------
module mtm_cos_lut #(
  parameter int unsigned TBITS = 10
) (
  input  logic               clk,
  input  logic               en,
  input  logic        [31:0] phase,
  output logic signed [31:0] cos_val
);

  localparam int unsigned QLEN = 1 << TBITS;

  logic [30:0]      qtab [QLEN + 1];
  logic [TBITS:0]   tidx_nxt;
  logic [TBITS:0]   tidx_r;
  logic             neg_r;
  logic [31:0]      mag_ext;
  logic signed [31:0] cos_nxt;
  logic signed [31:0] cos_r;

  for (genvar k = 0; k <= QLEN; k++) begin : g_tab
    assign qtab[k] = mtm_pkg::cos_entry(k, TBITS);
  end

  always_comb begin
    if (phase[30]) begin
      tidx_nxt = (TBITS + 1)'(QLEN) - {1'b0, phase[29:30-TBITS]};
    end else begin
      tidx_nxt = {1'b0, phase[29:30-TBITS]};
    end
  end

  assign mag_ext = {1'b0, qtab[tidx_r]};
  assign cos_nxt = neg_r ? -$signed(mag_ext) : $signed(mag_ext);

  always_ff @(posedge clk) begin
    if (en) begin
      tidx_r <= tidx_nxt;
      neg_r  <= phase[31] ^ phase[30];
      cos_r  <= cos_nxt;
    end
  end

  assign cos_val = cos_r;

endmodule

>>> sv/multitone_tune_modulator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multitone_tune_modulator_core
// per-turn modulated phase advance 2*pi*tune*(1 + epsilon*s), Q12.36 radians
// ----------------------------------------------------------------------------
// One word is taken every cycle while the result side does not stall. A word
// passes 25 register stages. The depth is set by the constant-divisor
// reductions of the multitone phase, the seven-lane cosine lookup and the
// 63 x 63 bit final product, which is done as four 32 bit partial products.
// A stall on the result side freezes the whole pipeline and drops in_tready.
// Each lane holds a quarter-wave cosine table of 2^COS_TABLE_BITS+1 entries.
// Configuration must be written only while no word is in flight; the block
// itself does not enforce this.
module multitone_tune_modulator_core #(
  parameter int unsigned COS_TABLE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // turn_index
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // phase_advance
  output logic [0:0]  out_tuser   // saturated
);

`include "multitone_tune_modulator_core_assert.svh"

  localparam int unsigned NSTG = 25;
  localparam int unsigned NT   = mtm_pkg::NUM_TONES;
  localparam logic signed [64:0] ONE_Q54 = 65'sd1 <<< 54;

  logic        mode_r;
  logic [31:0] tune_r;
  logic [31:0] epsilon_r;
  logic [31:0] tone_freq_r;
  logic [31:0] start_r;
  logic [62:0] w_r;

  logic            en;
  logic [NSTG-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      tune_r      <= '0;
      epsilon_r   <= '0;
      tone_freq_r <= '0;
      start_r     <= '0;
    end else if (cfg_wr_en) begin
      unique case (mtm_pkg::cfg_reg_t'(cfg_index))
        mtm_pkg::REG_MODE:         mode_r      <= cfg_wr_data[0];
        mtm_pkg::REG_TUNE:         tune_r      <= cfg_wr_data;
        mtm_pkg::REG_EPSILON:      epsilon_r   <= cfg_wr_data;
        mtm_pkg::REG_TONE_FREQ:    tone_freq_r <= cfg_wr_data;
        mtm_pkg::REG_START_OFFSET: start_r     <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // 2*pi*tune, Q60
  always_ff @(posedge clk) begin
    w_r <= tune_r * mtm_pkg::TWO_PI_Q28;
  end

  assign en        = !vld_r[NSTG-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_tvalid};
    end
  end

  // stage signals
  logic [63:0] tprod;
  logic [31:0] sph_r [1:10];
  logic [32:0] s1_nsum_r, s2_nsum_r;
  logic [49:0] qn_prod;
  logic [16:0] s2_qn_r;
  logic [32:0] nr_full;
  logic [17:0] s3_nr_r;
  logic [16:0] s4_n_r;

  logic [27:0] v_nxt    [NT];
  logic [26:0] v5_r     [NT];
  logic [26:0] v6_r     [NT];
  logic [37:0] q_prod   [NT];
  logic [10:0] q6_r     [NT];
  logic [26:0] r_full   [NT];
  logic [17:0] r7_r     [NT];
  logic [16:0] r8_r     [NT];
  logic [16:0] r9_r     [NT];
  logic [49:0] ph_prod  [NT];
  logic [31:0] q9_r     [NT];
  logic [31:0] q10_r    [NT];
  logic [48:0] rem_full [NT];
  logic [17:0] rem10_r  [NT];
  logic [31:0] ph11_r   [NT];
  logic signed [31:0] cos_w  [NT];
  logic signed [59:0] prd14_r [NT];

  logic signed [60:0] s15_r [4];
  logic signed [60:0] s16_r [2];
  logic signed [60:0] s70;
  logic signed [31:0] s17_r;
  logic signed [31:0] cdly_r [14:17];
  logic signed [31:0] mul_op;
  logic signed [64:0] prod18_r;
  logic signed [64:0] p54;
  logic signed [64:0] f_full;
  logic signed [63:0] f19_r;
  logic [62:0] fm20_r;
  logic [23:20] neg_r;
  logic [63:0] p00_r;
  logic [62:0] p01_r, p10_r;
  logic [61:0] p11_21_r, p11_22_r, p11_23_r;
  logic [63:0] mid22_r;
  logic [31:0] p00hi22_r;
  logic [64:0] low23_r;
  logic [61:0] hi;
  logic [47:0] mag24_r;
  logic        neg24_r;
  logic [47:0] res_r;
  logic        sat_r;

  assign tprod   = tone_freq_r * in_tdata;
  assign qn_prod = s1_nsum_r * mtm_pkg::RECIP_N;
  assign nr_full = s2_nsum_r - (33'(s2_qn_r) * 33'(mtm_pkg::PERIOD));

  always_comb begin
    for (int j = 0; j < NT; j++) begin
      v_nxt[j]    = s4_n_r * mtm_pkg::tone_mult(j);
      q_prod[j]   = v5_r[j] * mtm_pkg::RECIP_V;
      r_full[j]   = v6_r[j] - (27'(q6_r[j]) * 27'(mtm_pkg::PERIOD));
      ph_prod[j]  = r8_r[j] * mtm_pkg::RECIP_PH;
      rem_full[j] = {r9_r[j], 32'b0} - (49'(q9_r[j]) * 49'(mtm_pkg::PERIOD));
    end
  end

  for (genvar j = 0; j < NT; j++) begin : g_lane
    mtm_cos_lut #(
      .TBITS (COS_TABLE_BITS)
    ) u_cos (
      .clk     (clk),
      .en      (en),
      .phase   (ph11_r[j]),
      .cos_val (cos_w[j])
    );
  end

  assign s70    = s16_r[0] + s16_r[1];
  assign mul_op = mode_r ? s17_r : cdly_r[17];
  assign p54    = mode_r ? (prod18_r >>> 10) : prod18_r;
  assign f_full = p54 + ONE_Q54;
  assign hi     = p11_23_r + 62'(low23_r[64:32]);

  always_ff @(posedge clk) begin
    if (en) begin
      // phase generation
      sph_r[1]  <= tprod[31:0];
      for (int i = 2; i <= 10; i++) begin
        sph_r[i] <= sph_r[i-1];
      end
      s1_nsum_r <= {1'b0, in_tdata} + {1'b0, start_r};
      s2_nsum_r <= s1_nsum_r;
      s2_qn_r   <= qn_prod[49:33];
      s3_nr_r   <= nr_full[17:0];
      s4_n_r    <= (s3_nr_r >= 18'(mtm_pkg::PERIOD)) ?
                   17'(s3_nr_r - 18'(mtm_pkg::PERIOD)) : s3_nr_r[16:0];
      for (int j = 0; j < NT; j++) begin
        v5_r[j]    <= v_nxt[j][26:0];
        v6_r[j]    <= v5_r[j];
        q6_r[j]    <= q_prod[j][37:27];
        r7_r[j]    <= r_full[j][17:0];
        r8_r[j]    <= (r7_r[j] >= 18'(mtm_pkg::PERIOD)) ?
                      17'(r7_r[j] - 18'(mtm_pkg::PERIOD)) : r7_r[j][16:0];
        r9_r[j]    <= r8_r[j];
        q9_r[j]    <= ph_prod[j][48:17];
        q10_r[j]   <= q9_r[j];
        rem10_r[j] <= rem_full[j][17:0];
        if ((j == 0) && !mode_r) begin
          ph11_r[j] <= sph_r[10];
        end else begin
          ph11_r[j] <= q10_r[j] + 32'(rem10_r[j] >= 18'(mtm_pkg::PERIOD));
        end
        prd14_r[j] <= $signed({1'b0, mtm_pkg::tone_coef(j)}) * cos_w[j];
      end
      // weighted tone sum
      s15_r[0] <= prd14_r[0] + prd14_r[1];
      s15_r[1] <= prd14_r[2] + prd14_r[3];
      s15_r[2] <= prd14_r[4] + prd14_r[5];
      s15_r[3] <= 61'(prd14_r[6]);
      s16_r[0] <= s15_r[0] + s15_r[1];
      s16_r[1] <= s15_r[2] + s15_r[3];
      s17_r    <= 32'(s70 >>> 30);
      cdly_r[14] <= cos_w[0];
      for (int i = 15; i <= 17; i++) begin
        cdly_r[i] <= cdly_r[i-1];
      end
      // depth and offset
      prod18_r <= $signed({1'b0, epsilon_r}) * mul_op;
      f19_r    <= f_full[63:0];
      neg_r[20] <= f19_r[63];
      fm20_r   <= f19_r[63] ? 63'(-f19_r) : 63'(f19_r);
      // 63 x 63 product in 32 bit pieces
      p00_r    <= w_r[31:0] * fm20_r[31:0];
      p01_r    <= w_r[31:0] * fm20_r[62:32];
      p10_r    <= w_r[62:32] * fm20_r[31:0];
      p11_21_r <= w_r[62:32] * fm20_r[62:32];
      neg_r[21] <= neg_r[20];
      mid22_r   <= 64'(p01_r) + 64'(p10_r);
      p00hi22_r <= p00_r[63:32];
      p11_22_r  <= p11_21_r;
      neg_r[22] <= neg_r[21];
      low23_r   <= 65'(mid22_r) + 65'(p00hi22_r);
      p11_23_r  <= p11_22_r;
      neg_r[23] <= neg_r[22];
      mag24_r   <= hi[61:14];
      neg24_r   <= neg_r[23];
      // clip and sign
      if (!neg24_r && (mag24_r > mtm_pkg::POS_LIMIT)) begin
        res_r <= mtm_pkg::POS_LIMIT;
        sat_r <= 1'b1;
      end else if (neg24_r && (mag24_r > mtm_pkg::NEG_LIMIT)) begin
        res_r <= mtm_pkg::NEG_LIMIT;
        sat_r <= 1'b1;
      end else begin
        res_r <= neg24_r ? (48'd0 - mag24_r) : mag24_r;
        sat_r <= 1'b0;
      end
    end
  end

  assign out_tvalid   = vld_r[NSTG-1];
  assign out_tdata    = res_r;
  assign out_tuser[0] = sat_r;

  `MTM_ASSERT_IMP(a_sat_at_limit, clk, rst_n, out_tvalid && out_tuser[0], (out_tdata == mtm_pkg::POS_LIMIT) || (out_tdata == mtm_pkg::NEG_LIMIT))
  `MTM_ASSERT_IMP(a_stall_only_when_full, clk, rst_n, !in_tready, out_tvalid && !out_tready)
  `MTM_ASSERT_NXT(a_pipe_frozen, clk, rst_n, !in_tready, $stable(vld_r))

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the tune modulator: turn indices are streamed in
// with random gaps, each phase advance is predicted from the register settings
// and compared with the word that comes out, under random output stalls
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned TAB_BITS = 10;
  localparam int unsigned QLEN = 1 << TAB_BITS;
  localparam int unsigned LATENCY = 25;
  localparam int unsigned WATCHDOG = 20000;
  localparam longint unsigned PER = 86812;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [0:0]  out_tuser;

  typedef struct packed {
    logic [47:0] phase_adv;
    logic        sat;
  } advance_t;

  logic [31:0] turn_q[$];
  advance_t    advance_q[$];
  logic [30:0] qtab[QLEN+1];

  logic        cur_mode = 1'b0;
  logic [31:0] cur_tune = '0, cur_eps = '0, cur_freq = '0, cur_start = '0;

  int  n_fail = 0;
  int  quiet_cycles = 0;
  bit  calm = 1'b0;
  bit  feeding = 1'b0;
  int  in_gap = 0, out_gap = 0;

  multitone_tune_modulator_core #(.COS_TABLE_BITS(TAB_BITS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // quarter-wave table, taylor series in Q30
  function automatic void fill_qtab();
    logic [63:0] x, x2, term;
    longint s;
    for (int k = 0; k <= QLEN; k++) begin
      x = (64'(k) * 64'd6746518852) >> (TAB_BITS + 2);
      x2 = (x * x) >> 30;
      term = 64'd1 << 30;
      s = 64'sd1 << 30;
      for (int n = 1; n <= 10; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
        if (n % 2 == 1) s -= longint'(term);
        else s += longint'(term);
      end
      if (s < 0) s = 0;
      if (s > (64'sd1 << 30)) s = 64'sd1 << 30;
      qtab[k] = s[30:0];
    end
  endfunction

  function automatic longint cos_q30(logic [31:0] ph);
    int unsigned i;
    i = (ph >> (30 - TAB_BITS)) & (QLEN - 1);
    case (ph[31:30])
      2'd0: return longint'(qtab[i]);
      2'd1: return -longint'(qtab[QLEN - i]);
      2'd2: return -longint'(qtab[i]);
      default: return longint'(qtab[QLEN - i]);
    endcase
  endfunction

  function automatic advance_t predict_advance(logic [31:0] turn);
    advance_t r;
    longint p54, s70, s40;
    logic signed [127:0] f, fm, prod;
    logic [63:0] ph64;
    longint unsigned n, rr;
    logic [31:0] ph;
    logic [63:0] w;
    logic [127:0] mag;
    bit neg;
    if (!cur_mode) begin
      ph64 = 64'(cur_freq) * 64'(turn);
      p54 = longint'({32'd0, cur_eps}) * cos_q30(ph64[31:0]);
    end else begin
      n = (64'(turn) + 64'(cur_start)) % PER;
      s70 = 0;
      for (int j = 0; j < mtm_pkg::NUM_TONES; j++) begin
        rr = (n * 64'(mtm_pkg::tone_mult(j))) % PER;
        ph = 32'((rr << 32) / PER);
        s70 += longint'({37'd0, mtm_pkg::tone_coef(j)}) * cos_q30(ph);
      end
      s40 = s70 >>> 30;
      prod = 128'(signed'({32'd0, cur_eps})) * 128'(s40);
      p54 = longint'(prod >>> 10);
    end
    f = (128'sd1 <<< 54) + 128'(p54);
    neg = f < 0;
    fm = neg ? -f : f;
    w = 64'(cur_tune) * 64'd1686629713;
    mag = (128'(w) * 128'(fm)) >> 78;
    r.sat = 1'b0;
    if (!neg && mag > 128'h7FFF_FFFF_FFFF) begin
      mag = 128'h7FFF_FFFF_FFFF; r.sat = 1'b1;
    end else if (neg && mag > 128'h8000_0000_0000) begin
      mag = 128'h8000_0000_0000; r.sat = 1'b1;
    end
    r.phase_adv = neg ? 48'(-mag) : mag[47:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp_v);
    $display("mismatch %s: got %h expected %h", what, got, exp_v);
    n_fail++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        advance_q = {advance_q, predict_advance(in_tdata)};
      end
      if (!(in_tvalid && !in_tready)) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (feeding && turn_q.size() > 0) begin
          if (!calm && $urandom_range(0, 5) == 0) begin
            in_gap <= $urandom_range(0, 11);
            in_tvalid <= 1'b0;
          end else begin
            in_tdata <= turn_q.pop_front();
            in_tvalid <= 1'b1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    advance_t e;
    if (rst_n) begin
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (out_tvalid && out_tready) begin
        if (advance_q.size() == 0) begin
          report_mismatch("unexpected word", longint'(out_tdata), 0);
        end else begin
          e = advance_q.pop_front();
          if (out_tdata !== e.phase_adv)
            report_mismatch("phase_advance", longint'(out_tdata), longint'(e.phase_adv));
          if (out_tuser[0] !== e.sat)
            report_mismatch("saturated", longint'(out_tuser), longint'(e.sat));
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_gap <= $urandom_range(0, 11);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
      if (quiet_cycles > WATCHDOG) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic write_reg(mtm_pkg::cfg_reg_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      mtm_pkg::REG_MODE: cur_mode = val[0];
      mtm_pkg::REG_TUNE: cur_tune = val;
      mtm_pkg::REG_EPSILON: cur_eps = val;
      mtm_pkg::REG_TONE_FREQ: cur_freq = val;
      mtm_pkg::REG_START_OFFSET: cur_start = val;
      default: ;
    endcase
  endtask

  task automatic run_words();
    feeding = 1'b1;
    while (turn_q.size() > 0 || in_tvalid || advance_q.size() > 0) @(posedge clk);
    feeding = 1'b0;
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic set_all(logic [31:0] m, logic [31:0] t, logic [31:0] e,
                         logic [31:0] fq, logic [31:0] so);
    write_reg(mtm_pkg::REG_MODE, m);
    write_reg(mtm_pkg::REG_TUNE, t);
    write_reg(mtm_pkg::REG_EPSILON, e);
    write_reg(mtm_pkg::REG_TONE_FREQ, fq);
    write_reg(mtm_pkg::REG_START_OFFSET, so);
  endtask

  initial begin
    fill_qtab();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // directed: extremes of index and of every register
    set_all(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h4000_0000, 32'd0);
    turn_q = {32'd0, 32'd1, 32'd2, 32'd3, 32'hFFFF_FFFF, 32'h8000_0000};
    run_words();
    set_all(32'hFFFF_FFFE, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    turn_q = {32'd0, 32'hFFFF_FFFF, 32'd7};
    run_words();
    set_all(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    turn_q = {32'd0, 32'd1, 32'hFFFF_FFFF, 32'd86811, 32'd86812, 32'd12345};
    run_words();
    set_all(32'd1, 32'h1234_5678, 32'h0100_0000, 32'd0, 32'd0);
    turn_q = {32'd0, 32'd217, 32'd434, 32'hFFFF_FFFF};
    run_words();
    // random phases with random settings
    for (int p = 0; p < 10; p++) begin
      if (p == 8) calm = 1'b1;
      set_all($urandom_range(0, 3), $urandom(),
              (p % 3 == 0) ? 32'hFFFF_FFFF : $urandom(),
              $urandom(), $urandom());
      for (int i = 0; i < 72; i++)
        turn_q = {turn_q,
                  32'(($urandom_range(0, 1)) ? $urandom() : $urandom_range(0, 200000))};
      run_words();
    end
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
